// File: sv/rhh_pkg.sv
// Shared types and codes for the Robin Hood hash table.
package rhh_pkg;

    typedef enum logic [1:0] {
        CMD_FIND   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

endpackage

// File: sv/rhh_if.sv
// Valid/ready channel interface used for every stream of the hash table.
interface rhh_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/robin_hood_hash_table_top.sv
// Top level of the Robin Hood hash table with backward-shift delete.
//
//  Channel  | Direction | Beat contents
//  cmd      | in        | command, key, hash_value
//  res      | out       | status, slot_index, entries_held
//  cfg      | in        | slot count in use (9 bits), clears the table
//
// The front end works out each command's home slot as the serial remainder of the hash.
// The back end probes each slot through S_WAIT and S_PROBE, and takes each slot of the
// backward shift through S_SHIFT, S_SWAIT and S_SDO, as the slot RAM read is registered.
// Reset is synchronous and empties the table; no clearing pass is needed.
// A two-entry queue lets the front end work on the next command while the back end runs.
// A finished beat waits in an output register, so the back end moves on while it waits.
module robin_hood_hash_table_top
    import rhh_pkg::*;
#(
    parameter int SLOTS    = 256,
    parameter int KEY_BITS = 32
) (
    input logic i_clk,
    input logic i_rst_n,
    rhh_if.sink   cmd,
    rhh_if.source res,
    rhh_if.sink   cfg
);
    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int QW = 2 + KEY_BITS + AW;

    logic [CW-1:0] r_buckets;
    logic          flush;
    logic          q_valid, q_ready;
    logic [QW-1:0] q_data;
    logic [8:0]    wval;

    assign cfg.ready = 1'b1;
    assign flush     = cfg.valid;
    assign wval      = cfg.data[8:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buckets <= CW'(SLOTS);
        end else if (cfg.valid) begin
            if (wval == 9'd0) begin
                r_buckets <= CW'(1);
            end else if (32'(wval) > SLOTS) begin
                r_buckets <= CW'(SLOTS);
            end else begin
                r_buckets <= CW'(wval);
            end
        end
    end

    rhh_front #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd.valid),
        .o_cmd_ready (cmd.ready),
        .i_command   (cmd.data[65:64]),
        .i_key       (cmd.data[63:32]),
        .i_hash      (cmd.data[31:0]),
        .i_buckets   (r_buckets),
        .i_flush     (flush),
        .o_q_valid   (q_valid),
        .i_q_ready   (q_ready),
        .o_q_data    (q_data)
    );

    rhh_back #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_buckets   (r_buckets),
        .i_flush     (flush),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_data    (q_data),
        .o_res_valid (res.valid),
        .i_res_ready (res.ready),
        .o_status    (res.data[18:17]),
        .o_slot      (res.data[16:9]),
        .o_entries   (res.data[8:0])
    );
endmodule

// File: sv/rhh_ram.sv
// Generic single-port RAM with registered read data.
module rhh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: sv/rhh_front.sv
// Front end: accepts commands, works out the home slot by serial remainder, queues work.
module rhh_front
    import rhh_pkg::*;
#(
    parameter int SLOTS    = 256,
    parameter int KEY_BITS = 32,
    localparam int AW      = $clog2(SLOTS),
    localparam int CW      = $clog2(SLOTS + 1),
    localparam int QW      = 2 + KEY_BITS + AW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  logic [1:0]    i_command,
    input  logic [31:0]   i_key,
    input  logic [31:0]   i_hash,
    input  logic [CW-1:0] i_buckets,
    input  logic          i_flush,
    output logic          o_q_valid,
    input  logic          i_q_ready,
    output logic [QW-1:0] o_q_data
);
    logic                r_busy, n_busy;
    logic [5:0]          r_cnt, n_cnt;
    logic [31:0]         r_hash, n_hash;
    logic [CW:0]         r_rem, n_rem;
    logic [1:0]          r_cmd, n_cmd;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [QW-1:0]       r_q [2];
    logic [1:0]          r_qv, n_qv;
    logic                r_wp, r_rp;
    logic                push, pop;
    logic [CW:0]         shifted;

    assign o_cmd_ready = !r_busy && !i_flush;
    assign shifted     = {r_rem[CW-1:0], r_hash[31]};
    assign push        = r_busy && (r_cnt == 6'd32) && !r_qv[r_wp];
    assign o_q_valid   = r_qv[r_rp];
    assign o_q_data    = r_q[r_rp];
    assign pop         = o_q_valid && i_q_ready;

    always_comb begin
        n_qv = r_qv;
        if (push) begin
            n_qv[r_wp] = 1'b1;
        end
        if (pop) begin
            n_qv[r_rp] = 1'b0;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_hash = r_hash;
        n_rem  = r_rem;
        n_cmd  = r_cmd;
        n_key  = r_key;
        if (i_cmd_valid && o_cmd_ready) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_hash = i_hash;
            n_rem  = '0;
            n_cmd  = i_command;
            n_key  = KEY_BITS'(i_key);
        end else if (r_busy && r_cnt != 6'd32) begin
            n_hash = {r_hash[30:0], 1'b0};
            n_cnt  = r_cnt + 6'd1;
            if (shifted >= {1'b0, i_buckets}) begin
                n_rem = shifted - {1'b0, i_buckets};
            end else begin
                n_rem = shifted;
            end
        end else if (push) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_qv   <= '0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_qv   <= n_qv;
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
        end
        r_hash <= n_hash;
        r_rem  <= n_rem;
        r_cmd  <= n_cmd;
        r_key  <= n_key;
        if (push) begin
            r_q[r_wp] <= {r_cmd, r_key, r_rem[AW-1:0]};
        end
    end
endmodule

// File: sv/rhh_back.sv
// Back end: probes, inserts and removes one slot a step, and clears the slot store at once.
module rhh_back
    import rhh_pkg::*;
#(
    parameter int SLOTS    = 256,
    parameter int KEY_BITS = 32,
    localparam int AW      = $clog2(SLOTS),
    localparam int CW      = $clog2(SLOTS + 1),
    localparam int QW      = 2 + KEY_BITS + AW,
    localparam int EW      = KEY_BITS + AW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [CW-1:0] i_buckets,
    input  logic          i_flush,
    input  logic          i_q_valid,
    output logic          o_q_ready,
    input  logic [QW-1:0] i_q_data,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output logic [1:0]    o_status,
    output logic [7:0]    o_slot,
    output logic [8:0]    o_entries
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_WAIT  = 8'b0000_0100,
        S_PROBE = 8'b0000_1000,
        S_SHIFT = 8'b0001_0000,
        S_SWAIT = 8'b0010_0000,
        S_SDO   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [SLOTS-1:0]    r_valid, n_valid;
    logic [CW-1:0]       r_count, n_count;
    t_cmd                r_cmd, n_cmd;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [AW-1:0]       r_home, n_home;
    logic [AW-1:0]       r_pos, n_pos;
    logic [AW-1:0]       r_prev, n_prev;
    logic [CW-1:0]       r_psl, n_psl;
    logic [AW-1:0]       r_placed, n_placed;
    logic                r_first, n_first;
    logic                r_ov, n_ov;
    t_status             r_st, n_st;
    logic [AW-1:0]       r_oslot, n_oslot;
    t_status             r_res_st, n_res_st;
    logic [AW-1:0]       r_res_slot, n_res_slot;
    logic [CW-1:0]       r_res_held, n_res_held;

    logic                we;
    logic [AW-1:0]       addr;
    logic [EW-1:0]       wdata, rdata;
    logic                set_v, clr_v;
    logic [AW-1:0]       set_a, clr_a;
    logic [KEY_BITS-1:0] rd_key;
    logic [AW-1:0]       rd_home;
    logic [CW-1:0]       probe_d, nxt_full;
    logic [AW-1:0]       nxt;

    assign rd_key  = rdata[EW-1:AW];
    assign rd_home = rdata[AW-1:0];
    assign probe_d = (r_pos >= rd_home) ? CW'(r_pos) - CW'(rd_home)
                                        : CW'(r_pos) + i_buckets - CW'(rd_home);
    assign nxt_full = CW'(r_pos) + CW'(1);
    assign nxt      = (nxt_full >= i_buckets) ? '0 : r_pos + AW'(1);

    assign o_q_ready   = (r_state == S_IDLE) && !i_flush;
    assign o_res_valid = r_ov;
    assign o_status    = r_res_st;
    assign o_slot      = 8'(r_res_slot);
    assign o_entries   = 9'(r_res_held);

    rhh_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_home     = r_home;
        n_pos      = r_pos;
        n_prev     = r_prev;
        n_psl      = r_psl;
        n_placed   = r_placed;
        n_first    = r_first;
        n_ov       = r_ov;
        n_st       = r_st;
        n_oslot    = r_oslot;
        n_res_st   = r_res_st;
        n_res_slot = r_res_slot;
        n_res_held = r_res_held;
        we         = 1'b0;
        addr       = r_pos;
        wdata      = {r_key, r_home};
        set_v      = 1'b0;
        set_a      = r_pos;
        clr_v      = 1'b0;
        clr_a      = r_pos;
        if (r_ov && i_res_ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && o_q_ready) begin
                    n_cmd    = t_cmd'(i_q_data[QW-1:QW-2]);
                    n_key    = i_q_data[QW-3:AW];
                    n_home   = i_q_data[AW-1:0];
                    n_pos    = i_q_data[AW-1:0];
                    n_placed = i_q_data[AW-1:0];
                    n_psl    = '0;
                    n_first  = 1'b1;
                    n_st     = ST_OK;
                    n_oslot  = '0;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                if (r_cmd == CMD_CLEAR) begin
                    n_count = '0;
                    n_state = S_DONE;
                end else if (r_cmd == CMD_INSERT && r_count >= i_buckets) begin
                    n_st    = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (r_cmd == CMD_INSERT) begin
                    if (!r_valid[r_pos]) begin
                        we    = 1'b1;
                        set_v = 1'b1;
                        if (r_first) begin
                            n_placed = r_pos;
                        end
                        n_oslot = r_first ? r_pos : r_placed;
                        n_count = r_count + CW'(1);
                        n_state = S_DONE;
                    end else begin
                        if (probe_d < r_psl) begin
                            we      = 1'b1;
                            n_key   = rd_key;
                            n_home  = rd_home;
                            n_psl   = probe_d + CW'(1);
                            if (r_first) begin
                                n_placed = r_pos;
                                n_first  = 1'b0;
                            end
                        end else begin
                            n_psl = r_psl + CW'(1);
                        end
                        n_pos   = nxt;
                        n_state = S_WAIT;
                        addr    = r_pos;
                    end
                end else begin
                    if (!r_valid[r_pos] || probe_d < r_psl || r_psl >= i_buckets) begin
                        n_st    = ST_NOT_FOUND;
                        n_state = S_DONE;
                    end else if (rd_key == r_key) begin
                        n_oslot = r_pos;
                        if (r_cmd == CMD_REMOVE) begin
                            clr_v   = 1'b1;
                            n_prev  = r_pos;
                            n_pos   = nxt;
                            n_count = r_count - CW'(1);
                            n_state = S_SHIFT;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else begin
                        n_psl   = r_psl + CW'(1);
                        n_pos   = nxt;
                        n_state = S_WAIT;
                    end
                end
            end
            S_SHIFT: begin
                n_state = S_SWAIT;
            end
            S_SWAIT: begin
                n_state = S_SDO;
            end
            S_SDO: begin
                if (!r_valid[r_pos] || probe_d == '0 || r_pos == r_oslot) begin
                    n_state = S_DONE;
                end else begin
                    we      = 1'b1;
                    addr    = r_prev;
                    wdata   = rdata;
                    set_v   = 1'b1;
                    set_a   = r_prev;
                    clr_v   = 1'b1;
                    clr_a   = r_pos;
                    n_prev  = r_pos;
                    n_pos   = nxt;
                    n_state = S_SHIFT;
                end
            end
            S_DONE: begin
                if (!r_ov || i_res_ready) begin
                    n_ov       = 1'b1;
                    n_res_st   = r_st;
                    n_res_slot = r_oslot;
                    n_res_held = r_count;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (r_state == S_READ && r_cmd == CMD_CLEAR) begin
            n_valid = '0;
        end else begin
            if (clr_v) begin
                n_valid[clr_a] = 1'b0;
            end
            if (set_v) begin
                n_valid[set_a] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
            r_valid <= n_valid;
        end
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_home     <= n_home;
        r_pos      <= n_pos;
        r_prev     <= n_prev;
        r_psl      <= n_psl;
        r_placed   <= n_placed;
        r_first    <= n_first;
        r_st       <= n_st;
        r_oslot    <= n_oslot;
        r_res_st   <= n_res_st;
        r_res_slot <= n_res_slot;
        r_res_held <= n_res_held;
    end
endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the Robin Hood hash table top level.
`timescale 1ns / 1ps

module tb_top;
    import rhh_pkg::*;

    localparam int SLOTS = 256;

    typedef struct packed {
        t_status    status;
        logic [7:0] slot;
        logic [8:0] held;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rhh_if #(.W(66)) cmd_ch ();
    rhh_if #(.W(19)) res_ch ();
    rhh_if #(.W(9))  cfg_ch ();

    robin_hood_hash_table_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cmd     (cmd_ch.sink),
        .res     (res_ch.source),
        .cfg     (cfg_ch.sink)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the table.
    bit          tbl_valid [SLOTS];
    logic [31:0] tbl_key [SLOTS];
    int          tbl_home [SLOTS];
    int          tbl_count;
    int          buckets;

    t_outcome    pending [$];
    int          n_errors;
    int          n_sent;
    int          n_checked;
    int          n_full;
    int          n_missed;
    bit          hold_off;
    bit          no_idle;

    logic [31:0] pool_key [24];
    logic [31:0] pool_hash [24];

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        res_ch.ready = 1'b0;
    end

    function automatic int dist_at(int pos);
        return (pos >= tbl_home[pos]) ? pos - tbl_home[pos] : pos + buckets - tbl_home[pos];
    endfunction

    function automatic int step_pos(int pos);
        return (pos + 1 >= buckets) ? 0 : pos + 1;
    endfunction

    function automatic void empty_table();
        for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
        end
        tbl_count = 0;
    endfunction

    function automatic bit lookup(logic [31:0] key, int home, output int where);
        int pos;
        pos = home;
        where = 0;
        for (int psl = 0; psl < buckets; psl++) begin
            if (!tbl_valid[pos] || dist_at(pos) < psl) return 1'b0;
            if (tbl_key[pos] == key) begin
                where = pos;
                return 1'b1;
            end
            pos = step_pos(pos);
        end
        return 1'b0;
    endfunction

    function automatic int place_key(logic [31:0] key, int home);
        int pos, psl, placed, d, h2;
        bit first;
        logic [31:0] k2;
        pos = home;
        psl = 0;
        placed = home;
        first = 1'b1;
        for (int n = 0; n < buckets; n++) begin
            if (!tbl_valid[pos]) begin
                tbl_valid[pos] = 1'b1;
                tbl_key[pos] = key;
                tbl_home[pos] = home;
                if (first) placed = pos;
                break;
            end
            d = dist_at(pos);
            if (d < psl) begin
                k2 = tbl_key[pos];
                h2 = tbl_home[pos];
                tbl_key[pos] = key;
                tbl_home[pos] = home;
                if (first) begin
                    placed = pos;
                    first = 1'b0;
                end
                key = k2;
                home = h2;
                psl = d;
            end
            pos = step_pos(pos);
            psl++;
        end
        tbl_count++;
        return placed;
    endfunction

    function automatic void delete_at(int pos);
        int prev, cur;
        prev = pos;
        tbl_valid[pos] = 1'b0;
        cur = step_pos(pos);
        for (int n = 0; n < buckets; n++) begin
            if (!tbl_valid[cur] || dist_at(cur) == 0) break;
            tbl_valid[prev] = 1'b1;
            tbl_key[prev] = tbl_key[cur];
            tbl_home[prev] = tbl_home[cur];
            tbl_valid[cur] = 1'b0;
            prev = cur;
            cur = step_pos(cur);
        end
        if (tbl_count > 0) tbl_count--;
    endfunction

    function automatic t_outcome apply_command(t_cmd op, logic [31:0] key, logic [31:0] hash);
        t_outcome r;
        int home, where;
        home = int'(hash % buckets);
        r.status = ST_OK;
        r.slot = '0;
        case (op)
            CMD_FIND: begin
                if (lookup(key, home, where)) r.slot = where[7:0];
                else r.status = ST_NOT_FOUND;
            end
            CMD_INSERT: begin
                if (tbl_count >= buckets) r.status = ST_FULL;
                else r.slot = 8'(place_key(key, home));
            end
            CMD_REMOVE: begin
                if (lookup(key, home, where)) begin
                    r.slot = where[7:0];
                    delete_at(where);
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            default: begin
                empty_table();
            end
        endcase
        r.held = tbl_count[8:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (hold_off) begin
            res_ch.ready <= 1'b0;
        end else if (no_idle) begin
            res_ch.ready <= 1'b1;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= 28);
        end
    end

    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            if (pending.size() == 0) begin
                $error("result beat with no expectation waiting");
                n_errors++;
            end else begin
                want = pending.pop_front();
                n_checked++;
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    n_errors++;
                end
                if (got.slot !== want.slot) begin
                    $error("slot_index: expected %0d, got %0d", want.slot, got.slot);
                    n_errors++;
                end
                if (got.held !== want.held) begin
                    $error("entries_held: expected %0d, got %0d", want.held, got.held);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_cmd(t_cmd op, logic [31:0] key, logic [31:0] hash);
        t_outcome r;
        if (!no_idle && $urandom_range(0, 99) < 28) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data <= {op, key, hash};
        do @(posedge i_clk); while (!cmd_ch.ready);
        r = apply_command(op, key, hash);
        if (r.status == ST_FULL) n_full++;
        if (r.status == ST_NOT_FOUND) n_missed++;
        pending.push_back(r);
        n_sent++;
    endtask

    task automatic write_buckets(logic [8:0] value);
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending.size() != 0) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        buckets = (value == 0) ? 1 : ((value > SLOTS) ? SLOTS : int'(value));
        empty_table();
    endtask

    task automatic fill_pool();
        for (int i = 0; i < 24; i++) begin
            pool_key[i] = $urandom();
            pool_hash[i] = $urandom();
        end
    endtask

    task automatic random_cmd();
        int i, p;
        i = $urandom_range(0, 23);
        p = $urandom_range(0, 99);
        if (p < 8) send_cmd(t_cmd'($urandom_range(0, 2)), $urandom(), $urandom());
        else if (p < 50) send_cmd(CMD_INSERT, pool_key[i], pool_hash[i]);
        else if (p < 72) send_cmd(CMD_FIND, pool_key[i], pool_hash[i]);
        else if (p < 98) send_cmd(CMD_REMOVE, pool_key[i], pool_hash[i]);
        else send_cmd(CMD_CLEAR, $urandom(), $urandom());
    endtask

    task automatic test_basic_ops();
        send_cmd(CMD_FIND, 32'h0, 32'h0);
        send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_INSERT, 32'h0, 32'h0);
        send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_INSERT, 32'h1234_5678, 32'hFFFF_FFFF);
        send_cmd(CMD_INSERT, 32'h1234_5678, 32'h0000_00FF);
        send_cmd(CMD_INSERT, 32'hA5A5_5A5A, 32'h0000_00FE);
        send_cmd(CMD_FIND, 32'h1234_5678, 32'hFFFF_FFFF);
        send_cmd(CMD_FIND, 32'hA5A5_5A5A, 32'h0000_00FE);
        send_cmd(CMD_REMOVE, 32'h1234_5678, 32'hFFFF_FFFF);
        send_cmd(CMD_FIND, 32'h1234_5678, 32'hFFFF_FFFF);
        send_cmd(CMD_REMOVE, 32'h5A5A_A5A5, 32'h0000_0001);
        send_cmd(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_FIND, 32'h0, 32'h0);
    endtask

    task automatic test_bucket_limits();
        write_buckets(9'd0);
        send_cmd(CMD_INSERT, 32'h11, 32'h7);
        send_cmd(CMD_INSERT, 32'h22, 32'h9);
        send_cmd(CMD_FIND, 32'h11, 32'hFFFF_FFFF);
        write_buckets(9'd3);
        for (int i = 0; i < 4; i++) send_cmd(CMD_INSERT, 32'h40 + i, i);
        send_cmd(CMD_REMOVE, 32'h40, 32'h0);
        write_buckets(9'd511);
        send_cmd(CMD_INSERT, 32'h77, 32'hFFFF_FFFF);
        write_buckets(9'd300);
        send_cmd(CMD_FIND, 32'h77, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_mix();
        int sizes [5] = '{7, 1, 16, 64, 256};
        for (int ph = 0; ph < 5; ph++) begin
            write_buckets(9'(sizes[ph]));
            fill_pool();
            no_idle = (ph == 2);
            for (int n = 0; n < 190; n++) random_cmd();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        write_buckets(9'd32);
        fill_pool();
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 40; n++) random_cmd();
        join
    endtask

    initial begin
        n_errors = 0;
        buckets = SLOTS;
        empty_table();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_ops();
        test_bucket_limits();
        test_random_mix();
        test_backpressure();
        cmd_ch.valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Sent %0d commands and checked %0d results over bucket counts 1 to 256,",
                 n_sent, n_checked);
        $display("with %0d full-table refusals and %0d misses.", n_full, n_missed);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #80ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
sv/rhh_pkg.sv
sv/rhh_if.sv
sv/rhh_ram.sv
sv/rhh_front.sv
sv/rhh_back.sv
sv/robin_hood_hash_table_top.sv
sim/tb_top.sv
